// ===== rtl/core/boundary_tag_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Boundary tag allocator assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_ALLOCATOR_TOP_MACROS_SVH
`define BOUNDARY_TAG_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BTA_ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define BTA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// Boundary tag allocator package
// Shared constants, sequencer commands and datapath status flags.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int unsigned POOL_WORDS_DEF = 1024;
  localparam int unsigned MIN_SPLIT_W    = 10;
  localparam int unsigned REQ_W          = 11;
  localparam int unsigned ADDR_W         = 10;
  localparam int unsigned GSIZE_W        = 11;

  localparam logic [MIN_SPLIT_W-1:0] MIN_SPLIT_RST = 10'd10;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLR,
    OP_ACCEPT,
    OP_A_START,
    OP_A_SCAN,
    OP_F_START,
    OP_F_HEAD,
    OP_F_PREV,
    OP_F_NEXT,
    OP_N_SOLO,
    OP_N_PREP,
    OP_M_PREP,
    OP_B_PREP,
    OP_SPCLR,
    OP_LK_RD_F,
    OP_LK_WR_F,
    OP_LK_WR_H,
    OP_LK_RD_B,
    OP_LK_WR_B,
    OP_P_RD,
    OP_P_LD,
    OP_WR_HEAD,
    OP_WR_FOOT,
    OP_SPLIT2,
    OP_RES_DONE,
    OP_RES_REFUSE
  } cmd_e;

  typedef struct packed {
    logic empty;
    logic fit;
    logic last;
    logic split;
    logic single;
    logic addr_ok;
    logic mark;
    logic pfree;
    logic nfree;
    logic nx_single;
    logic out_free;
    logic clr_last;
    logic in_op;
  } status_t;

endpackage

// ===== rtl/core/bta_dpath.sv =====
// ----------------------------------------------------------------------------
// Boundary tag allocator datapath
// Pool memory, list pointers, working registers and the result register.
// ----------------------------------------------------------------------------
module bta_dpath #(
  parameter int unsigned POOL_WORDS = bta_pkg::POOL_WORDS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bta_pkg::cmd_e                    cmd_i,
  output bta_pkg::status_t                 st_o,
  input  logic                             operation_i,
  input  logic [bta_pkg::REQ_W-1:0]        request_size_i,
  input  logic [bta_pkg::ADDR_W-1:0]       block_addr_i,
  input  logic                             cfg_valid_i,
  input  logic [bta_pkg::MIN_SPLIT_W-1:0]  cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             status_o,
  output logic [bta_pkg::ADDR_W-1:0]       granted_addr_o,
  output logic [bta_pkg::GSIZE_W-1:0]      granted_size_o
);
  import bta_pkg::*;

  localparam int unsigned POOL_TOTAL = POOL_WORDS + 2;
  localparam int unsigned AW = $clog2(POOL_TOTAL);
  localparam int unsigned SW = $clog2(POOL_WORDS + 1);
  localparam int unsigned CW = (SW > REQ_W) ? SW : REQ_W;

  typedef struct packed {
    logic          tag;
    logic          mark;
    logic [SW-1:0] size;
    logic [AW-1:0] back;
    logic [AW-1:0] fwd;
  } word_t;

  word_t mem [POOL_TOTAL];
  word_t rd_q;

  logic                   we;
  logic [AW-1:0]          wa;
  logic [AW-1:0]          ra;
  word_t                  wd;
  word_t                  init_word;

  logic [AW-1:0]          clr_q;
  logic [AW-1:0]          head_q;
  logic                   empty_q;
  logic [MIN_SPLIT_W-1:0] min_split_q;

  logic [REQ_W-1:0]       n_q;
  logic                   op_q;
  logic [ADDR_W-1:0]      blk_q;
  logic [AW-1:0]          sp_q;
  logic [AW-1:0]          p_q;
  word_t                  w_q;
  logic [SW-1:0]          acc_q;
  logic [AW-1:0]          pre_q;
  logic [AW-1:0]          x_q;
  logic [SW-1:0]          nxs_q;
  logic                   pfree_q;
  logic                   nxsingle_q;
  logic [AW-1:0]          b_q;
  logic [AW-1:0]          f_q;
  logic [AW-1:0]          bv_q;
  logic [AW-1:0]          fv_q;
  logic [AW-1:0]          ha_q;
  word_t                  hw_q;

  logic                   out_valid_q;
  logic                   res_status_q;
  logic [ADDR_W-1:0]      res_addr_q;
  logic [GSIZE_W-1:0]     res_size_q;

  logic [SW-1:0]          left;
  logic                   fit;
  logic                   split;
  logic [AW-1:0]          nx_addr;
  logic [AW-1:0]          foot_addr;

  assign left      = rd_q.size - SW'(n_q);
  assign fit       = CW'(rd_q.size) >= CW'(n_q);
  assign split     = (CW'(left) > CW'(min_split_q)) && (left >= SW'(2));
  assign nx_addr   = sp_q + AW'(acc_q);
  assign foot_addr = ha_q + AW'(hw_q.size) - AW'(1);

  always_comb begin
    init_word = '0;
    if ((clr_q == '0) || (clr_q == AW'(POOL_WORDS + 1))) begin
      init_word.tag = 1'b1;
    end else if (clr_q == AW'(1)) begin
      init_word.size = SW'(POOL_WORDS);
      init_word.back = AW'(1);
      init_word.fwd  = AW'(1);
    end else if (clr_q == AW'(POOL_WORDS)) begin
      init_word.back = AW'(1);
    end
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    ra = '0;
    wd = '0;
    case (cmd_i)
      OP_CLR: begin
        we = 1'b1;
        wa = clr_q;
        wd = init_word;
      end
      OP_A_START: ra = head_q;
      OP_A_SCAN:  ra = rd_q.fwd;
      OP_F_START: ra = sp_q;
      OP_F_HEAD:  ra = sp_q - AW'(1);
      OP_F_PREV:  ra = nx_addr;
      OP_SPCLR: begin
        we      = 1'b1;
        wa      = sp_q;
        wd      = w_q;
        wd.tag  = 1'b0;
        wd.mark = 1'b0;
      end
      OP_LK_RD_F: ra = f_q;
      OP_LK_WR_F, OP_LK_WR_H: begin
        we      = 1'b1;
        wa      = f_q;
        wd      = rd_q;
        wd.back = fv_q;
      end
      OP_LK_RD_B: ra = b_q;
      OP_LK_WR_B: begin
        we     = 1'b1;
        wa     = b_q;
        wd     = rd_q;
        wd.fwd = bv_q;
      end
      OP_P_RD: ra = pre_q;
      OP_WR_HEAD: begin
        we = 1'b1;
        wa = ha_q;
        wd = hw_q;
      end
      OP_WR_FOOT: begin
        we      = 1'b1;
        wa      = foot_addr;
        wd.tag  = hw_q.tag;
        wd.back = ha_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  // list head, empty flag, register and clear counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      head_q      <= AW'(1);
      empty_q     <= 1'b0;
      min_split_q <= MIN_SPLIT_RST;
    end else begin
      if (cfg_valid_i) begin
        min_split_q <= cfg_data_i;
      end
      case (cmd_i)
        OP_CLR: clr_q <= clr_q + AW'(1);
        OP_A_SCAN: begin
          if (fit) begin
            head_q <= rd_q.fwd;
            if (!split && (rd_q.fwd == p_q)) begin
              empty_q <= 1'b1;
            end
          end
        end
        OP_N_SOLO: begin
          head_q  <= sp_q;
          empty_q <= 1'b0;
        end
        OP_N_PREP: head_q <= sp_q;
        OP_M_PREP: begin
          if (head_q == x_q) begin
            head_q <= sp_q;
          end
        end
        OP_B_PREP: begin
          if (head_q == x_q) begin
            head_q <= pre_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      OP_ACCEPT: begin
        n_q   <= (request_size_i < REQ_W'(2)) ? REQ_W'(2) : request_size_i;
        op_q  <= operation_i;
        blk_q <= block_addr_i;
        sp_q  <= AW'(32'(block_addr_i) + 32'd1);
      end
      OP_A_START: p_q <= head_q;
      OP_A_SCAN: begin
        w_q <= rd_q;
        if (!fit) begin
          p_q <= rd_q.fwd;
        end else begin
          ha_q <= p_q;
          b_q  <= rd_q.back;
          f_q  <= rd_q.fwd;
          bv_q <= rd_q.fwd;
          fv_q <= rd_q.back;
          hw_q <= rd_q;
          if (split) begin
            hw_q.size <= left;
          end else begin
            hw_q.tag  <= 1'b1;
            hw_q.mark <= 1'b1;
          end
        end
      end
      OP_F_HEAD: begin
        w_q   <= rd_q;
        acc_q <= rd_q.size;
      end
      OP_F_PREV: begin
        pfree_q <= (rd_q.tag == 1'b0);
        pre_q   <= rd_q.back;
        x_q     <= nx_addr;
      end
      OP_F_NEXT: begin
        b_q        <= rd_q.back;
        f_q        <= rd_q.fwd;
        nxs_q      <= rd_q.size;
        nxsingle_q <= (rd_q.fwd == x_q);
      end
      OP_N_SOLO: begin
        ha_q <= sp_q;
        hw_q <= '{tag: 1'b0, mark: 1'b0, size: acc_q, back: sp_q, fwd: sp_q};
      end
      OP_N_PREP: begin
        f_q  <= head_q;
        fv_q <= sp_q;
        bv_q <= sp_q;
        ha_q <= sp_q;
        hw_q <= '{tag: 1'b0, mark: 1'b0, size: acc_q, back: head_q, fwd: head_q};
      end
      OP_LK_WR_H: begin
        b_q       <= rd_q.back;
        hw_q.back <= rd_q.back;
      end
      OP_M_PREP: begin
        ha_q <= sp_q;
        bv_q <= sp_q;
        fv_q <= sp_q;
        hw_q <= '{tag: 1'b0, mark: 1'b0, size: acc_q + nxs_q,
                  back: nxsingle_q ? sp_q : b_q, fwd: nxsingle_q ? sp_q : f_q};
      end
      OP_B_PREP: begin
        bv_q  <= f_q;
        fv_q  <= b_q;
        acc_q <= acc_q + nxs_q;
      end
      OP_P_LD: begin
        ha_q      <= pre_q;
        hw_q      <= rd_q;
        hw_q.size <= rd_q.size + acc_q;
      end
      OP_SPLIT2: begin
        ha_q      <= ha_q + AW'(hw_q.size);
        hw_q.tag  <= 1'b1;
        hw_q.mark <= 1'b1;
        hw_q.size <= SW'(n_q);
      end
      default: ;
    endcase
  end

  // result register, freed once the transaction leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i == OP_RES_DONE) || (cmd_i == OP_RES_REFUSE)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == OP_RES_DONE) begin
      res_status_q <= 1'b0;
      res_addr_q   <= op_q ? '0 : ADDR_W'(ha_q - AW'(1));
      res_size_q   <= op_q ? '0 : GSIZE_W'(hw_q.size);
    end else if (cmd_i == OP_RES_REFUSE) begin
      res_status_q <= 1'b1;
      res_addr_q   <= '0;
      res_size_q   <= '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_status_q;
  assign granted_addr_o = res_addr_q;
  assign granted_size_o = res_size_q;

  always_comb begin
    st_o           = '0;
    st_o.empty     = empty_q;
    st_o.fit       = fit;
    st_o.last      = (rd_q.fwd == head_q);
    st_o.split     = split;
    st_o.single    = (rd_q.fwd == p_q);
    st_o.addr_ok   = 32'(blk_q) < 32'(POOL_WORDS);
    st_o.mark      = rd_q.mark;
    st_o.pfree     = pfree_q;
    st_o.nfree     = (rd_q.tag == 1'b0);
    st_o.nx_single = nxsingle_q;
    st_o.out_free  = !out_valid_q || !out_stall_i;
    st_o.clr_last  = (clr_q == AW'(POOL_WORDS + 1));
    st_o.in_op     = operation_i;
  end

endmodule

// ===== rtl/core/bta_ctrl.sv =====
// ----------------------------------------------------------------------------
// Boundary tag allocator controller
// Sequencer stepping the datapath through clear, allocate and free.
// ----------------------------------------------------------------------------
module bta_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bta_pkg::status_t  st_i,
  output bta_pkg::cmd_e     cmd_o
);
  import bta_pkg::*;

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_A_START = 5'd2;
  localparam logic [4:0] S_A_SCAN  = 5'd3;
  localparam logic [4:0] S_F_START = 5'd4;
  localparam logic [4:0] S_F_HEAD  = 5'd5;
  localparam logic [4:0] S_F_PREV  = 5'd6;
  localparam logic [4:0] S_F_NEXT  = 5'd7;
  localparam logic [4:0] S_N_SOLO  = 5'd8;
  localparam logic [4:0] S_N_PREP  = 5'd9;
  localparam logic [4:0] S_M_PREP  = 5'd10;
  localparam logic [4:0] S_B_PREP  = 5'd11;
  localparam logic [4:0] S_SPCLR   = 5'd12;
  localparam logic [4:0] S_L_RD_F  = 5'd13;
  localparam logic [4:0] S_L_WR_F  = 5'd14;
  localparam logic [4:0] S_L_RD_B  = 5'd15;
  localparam logic [4:0] S_L_WR_B  = 5'd16;
  localparam logic [4:0] S_P_RD    = 5'd17;
  localparam logic [4:0] S_P_LD    = 5'd18;
  localparam logic [4:0] S_T_HEAD  = 5'd19;
  localparam logic [4:0] S_T_FOOT  = 5'd20;
  localparam logic [4:0] S_SPLIT2  = 5'd21;
  localparam logic [4:0] S_DONE    = 5'd22;
  localparam logic [4:0] S_REFUSE  = 5'd23;

  logic [4:0] state_q, state_d;
  logic       split_q, split_d;
  logic       nl_q, nl_d;
  logic       both_q, both_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    split_d = split_q;
    nl_d    = nl_q;
    both_d  = both_q;
    cmd_o   = OP_NOP;
    case (state_q)
      S_CLR: begin
        cmd_o = OP_CLR;
        if (st_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = OP_ACCEPT;
          split_d = 1'b0;
          nl_d    = 1'b0;
          both_d  = 1'b0;
          state_d = st_i.in_op ? S_F_START : S_A_START;
        end
      end
      S_A_START: begin
        cmd_o   = OP_A_START;
        state_d = st_i.empty ? S_REFUSE : S_A_SCAN;
      end
      // one free block per cycle
      S_A_SCAN: begin
        cmd_o = OP_A_SCAN;
        if (st_i.fit) begin
          if (st_i.split) begin
            split_d = 1'b1;
            state_d = S_T_HEAD;
          end else if (st_i.single) begin
            state_d = S_T_HEAD;
          end else begin
            state_d = S_L_RD_F;
          end
        end else if (st_i.last) begin
          state_d = S_REFUSE;
        end
      end
      S_F_START: begin
        cmd_o   = OP_F_START;
        state_d = st_i.addr_ok ? S_F_HEAD : S_REFUSE;
      end
      S_F_HEAD: begin
        cmd_o   = OP_F_HEAD;
        state_d = st_i.mark ? S_F_PREV : S_REFUSE;
      end
      S_F_PREV: begin
        cmd_o   = OP_F_PREV;
        state_d = S_F_NEXT;
      end
      S_F_NEXT: begin
        cmd_o = OP_F_NEXT;
        if (!st_i.pfree && !st_i.nfree) begin
          state_d = st_i.empty ? S_N_SOLO : S_N_PREP;
        end else if (st_i.pfree && !st_i.nfree) begin
          state_d = S_SPCLR;
        end else if (!st_i.pfree && st_i.nfree) begin
          state_d = S_M_PREP;
        end else begin
          state_d = S_B_PREP;
        end
      end
      S_N_SOLO: begin
        cmd_o   = OP_N_SOLO;
        state_d = S_T_HEAD;
      end
      S_N_PREP: begin
        cmd_o   = OP_N_PREP;
        nl_d    = 1'b1;
        state_d = S_L_RD_F;
      end
      S_M_PREP: begin
        cmd_o   = OP_M_PREP;
        state_d = st_i.nx_single ? S_T_HEAD : S_L_RD_F;
      end
      S_B_PREP: begin
        cmd_o   = OP_B_PREP;
        both_d  = 1'b1;
        state_d = S_SPCLR;
      end
      S_SPCLR: begin
        cmd_o   = OP_SPCLR;
        state_d = both_q ? S_L_RD_F : S_P_RD;
      end
      S_L_RD_F: begin
        cmd_o   = OP_LK_RD_F;
        state_d = S_L_WR_F;
      end
      S_L_WR_F: begin
        cmd_o   = nl_q ? OP_LK_WR_H : OP_LK_WR_F;
        state_d = S_L_RD_B;
      end
      S_L_RD_B: begin
        cmd_o   = OP_LK_RD_B;
        state_d = S_L_WR_B;
      end
      S_L_WR_B: begin
        cmd_o   = OP_LK_WR_B;
        state_d = both_q ? S_P_RD : S_T_HEAD;
      end
      S_P_RD: begin
        cmd_o   = OP_P_RD;
        state_d = S_P_LD;
      end
      S_P_LD: begin
        cmd_o   = OP_P_LD;
        state_d = S_T_HEAD;
      end
      S_T_HEAD: begin
        cmd_o   = OP_WR_HEAD;
        state_d = S_T_FOOT;
      end
      S_T_FOOT: begin
        cmd_o = OP_WR_FOOT;
        if (split_q) begin
          split_d = 1'b0;
          state_d = S_SPLIT2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SPLIT2: begin
        cmd_o   = OP_SPLIT2;
        state_d = S_T_HEAD;
      end
      // hold until the result register frees
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o   = OP_RES_DONE;
          state_d = S_IDLE;
        end
      end
      S_REFUSE: begin
        if (st_i.out_free) begin
          cmd_o   = OP_RES_REFUSE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      split_q <= 1'b0;
      nl_q    <= 1'b0;
      both_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      split_q <= split_d;
      nl_q    <= nl_d;
      both_q  <= both_d;
    end
  end

endmodule

// ===== rtl/core/boundary_tag_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Boundary tag allocator
// Next-fit heap manager over an on-chip pool with boundary tags.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one transaction: allocate
// request_size_i words or free the block at block_addr_i. Output channel
// (out_valid_o / out_stall_i) returns one result per transaction: status_o,
// granted_addr_o, granted_size_o. min_split is written on the cfg channel,
// which is always ready.
// One transaction at a time; each step makes at most one pool memory access.
// A new transaction is taken only once the last result has gone to the
// output register. Allocate scans the free list from its head and splits
// the fitting block, takes it whole when it is the only free block, or
// unlinks it; it is refused when the list is empty or the scan comes round.
// Free checks which neighbours are free and links or merges the block; a
// bad address is refused.
// After reset a clearing pass writes the POOL_WORDS + 2 pool words, one per
// cycle, with in_stall_o high; cfg writes are taken during it.
// A stalled result stays in the output register; the next transaction is
// accepted meanwhile and its result waits until that register frees.
// ----------------------------------------------------------------------------
module boundary_tag_allocator_top #(
  parameter int unsigned POOL_WORDS = bta_pkg::POOL_WORDS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic [bta_pkg::REQ_W-1:0]        request_size_i,
  input  logic [bta_pkg::ADDR_W-1:0]       block_addr_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             status_o,
  output logic [bta_pkg::ADDR_W-1:0]       granted_addr_o,
  output logic [bta_pkg::GSIZE_W-1:0]      granted_size_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bta_pkg::MIN_SPLIT_W-1:0]  cfg_data_i
);
  import bta_pkg::*;

  `include "boundary_tag_allocator_top_macros.svh"

  cmd_e    cmd;
  status_t st;

  assign cfg_ready_o = 1'b1;

  bta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bta_dpath #(
    .POOL_WORDS (POOL_WORDS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .operation_i    (operation_i),
    .request_size_i (request_size_i),
    .block_addr_i   (block_addr_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .granted_addr_o (granted_addr_o),
    .granted_size_o (granted_size_o)
  );

  `BTA_ASSERT_IMPLIES(a_refuse_empty, out_valid_o && status_o, (granted_addr_o == '0) && (granted_size_o == '0), "refused transaction carries a grant")
  `BTA_ASSERT_IMPLIES(a_grant_min, out_valid_o && !status_o && (granted_size_o != '0), granted_size_o >= 11'd2, "granted block smaller than head and foot")
  `BTA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "second transaction taken while busy")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Boundary tag allocator testbench
// Sends allocate and free transactions through the input channel and keeps a
// boundary-tag heap of its own in step with the block. Each grant or refusal
// is compared field by field with the predicted one, in order. Covers the
// whole pool, tiny and oversized requests, merges on both sides, bad frees,
// several split thresholds, random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import bta_pkg::*;

  localparam int unsigned POOL_N     = POOL_WORDS_DEF;
  localparam int unsigned POOL_ALL   = POOL_N + 2;
  localparam int unsigned CYCLE_MAX  = 10000000;
  localparam int unsigned SETTLE_CYC = 40;
  localparam bit          OP_ALLOC   = 1'b0;
  localparam bit          OP_FREE    = 1'b1;
  localparam bit          ST_DONE    = 1'b0;
  localparam bit          ST_REFUSED = 1'b1;

  typedef struct packed {
    logic                st;
    logic [ADDR_W-1:0]   ad;
    logic [GSIZE_W-1:0]  sz;
  } grant_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   operation_i = OP_ALLOC;
  logic [REQ_W-1:0]       request_size_i = '0;
  logic [ADDR_W-1:0]      block_addr_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   status_o;
  logic [ADDR_W-1:0]      granted_addr_o;
  logic [GSIZE_W-1:0]     granted_size_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [MIN_SPLIT_W-1:0] cfg_data_i = '0;

  // heap mirror
  int unsigned ptag [POOL_ALL];
  int unsigned psize[POOL_ALL];
  int unsigned pback[POOL_ALL];
  int unsigned pfwd [POOL_ALL];
  bit          pmark[POOL_ALL];
  int unsigned fhead;
  bit          fempty;
  int unsigned split_lim;
  int unsigned live_q[$];
  grant_t      grant_q[$];

  int unsigned cycles, errors, checked, n_alloc, n_free, n_refused;
  bit          no_idle = 1'b0;
  int unsigned pressure_req = 0, pressure_seen = 0, hold_left = 0;

  boundary_tag_allocator_top uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("%0t: timeout, %0d results outstanding", $realtime, grant_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned wrap(int unsigned a);
    return a < POOL_ALL ? a : 0;
  endfunction

  function automatic void put_foot(int unsigned h, int unsigned tg);
    int unsigned f;
    f = wrap(h + psize[wrap(h)] - 1);
    ptag[f]  = tg;
    pback[f] = h;
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < POOL_ALL; i++) begin
      ptag[i] = 0; psize[i] = 0; pback[i] = 0; pfwd[i] = 0; pmark[i] = 0;
    end
    ptag[0] = 1;
    ptag[POOL_ALL-1] = 1;
    psize[1] = POOL_N;
    pback[1] = 1;
    pfwd[1]  = 1;
    put_foot(1, 0);
    fhead = 1;
    fempty = 0;
    split_lim = MIN_SPLIT_RST;
  endfunction

  function automatic grant_t grant_alloc(int unsigned n);
    int unsigned p, left, b, f;
    grant_t g;
    g = '{ST_REFUSED, '0, '0};
    if (n < 2) n = 2;
    if (fempty) return g;
    p = wrap(fhead);
    for (int i = 0; i < POOL_ALL; i++) begin
      if (psize[p] >= n || wrap(pfwd[p]) == wrap(fhead)) break;
      p = wrap(pfwd[p]);
    end
    if (psize[p] < n) return g;
    fhead = wrap(pfwd[p]);
    left = psize[p] - n;
    if (left > split_lim && left >= 2) begin
      // cut from the high end, the remainder stays linked
      psize[p] = left;
      put_foot(p, 0);
      p = wrap(p + left);
      psize[p] = n;
    end else if (wrap(pfwd[p]) == p) begin
      fempty = 1;
    end else begin
      b = wrap(pback[p]);
      f = wrap(pfwd[p]);
      pfwd[b]  = f;
      pback[f] = b;
    end
    ptag[p] = 1;
    put_foot(p, 1);
    pmark[p] = 1;
    live_q.push_back(p - 1);
    g.st = ST_DONE;
    g.ad = ADDR_W'(p - 1);
    g.sz = GSIZE_W'(psize[p]);
    return g;
  endfunction

  function automatic bit release_block(int unsigned addr);
    int unsigned sp, s, pre, nx, b, f, h, last;
    bit pfree, nfree;
    sp = addr + 1;
    if (sp < 1 || sp > POOL_N || !pmark[sp]) return ST_REFUSED;
    pmark[sp] = 0;
    foreach (live_q[i]) if (live_q[i] == addr) begin
      live_q.delete(i);
      break;
    end
    s = psize[sp];
    pre = wrap(pback[sp-1]);
    nx = wrap(sp + s);
    pfree = ptag[sp-1] == 0;
    nfree = ptag[nx] == 0;
    ptag[sp] = 0;
    if (!pfree && !nfree) begin
      put_foot(sp, 0);
      if (fempty) begin
        pback[sp] = sp; pfwd[sp] = sp; fempty = 0;
      end else begin
        h = wrap(fhead);
        last = wrap(pback[h]);
        pfwd[sp] = h; pback[sp] = last;
        pback[h] = sp; pfwd[last] = sp;
      end
      fhead = sp;
    end else if (pfree && !nfree) begin
      psize[pre] += s;
      put_foot(pre, 0);
    end else if (!pfree && nfree) begin
      // take over the place of the following block in the list
      if (wrap(pfwd[nx]) == nx) begin
        pback[sp] = sp; pfwd[sp] = sp;
      end else begin
        b = wrap(pback[nx]);
        f = wrap(pfwd[nx]);
        pback[sp] = b; pfwd[sp] = f;
        pfwd[b] = sp; pback[f] = sp;
      end
      if (wrap(fhead) == nx) fhead = sp;
      psize[sp] = s + psize[nx];
      put_foot(sp, 0);
    end else begin
      b = wrap(pback[nx]);
      f = wrap(pfwd[nx]);
      pfwd[b] = f; pback[f] = b;
      if (wrap(fhead) == nx) fhead = pre;
      psize[pre] += s + psize[nx];
      put_foot(pre, 0);
    end
    return ST_DONE;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one transaction; called on a rising edge, returns on one
  task automatic send_item(input bit op, input int unsigned req, input int unsigned ad);
    grant_t g;
    int unsigned gap;
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    request_size_i <= REQ_W'(req);
    block_addr_i   <= ADDR_W'(ad);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == OP_ALLOC) begin
      g = grant_alloc(req & 11'h7FF);
      n_alloc++;
    end else begin
      g = '{release_block(ad & 10'h3FF), '0, '0};
      n_free++;
    end
    if (g.st == ST_REFUSED) n_refused++;
    grant_q.push_back(g);
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid, let every result come home, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_split(input int unsigned v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= MIN_SPLIT_W'(v);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    split_lim = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_result();
    grant_t g;
    if (grant_q.size() == 0) begin
      $display("%0t: unexpected result st=%0d addr=%0d size=%0d", $realtime,
               status_o, granted_addr_o, granted_size_o);
      errors++;
      return;
    end
    g = grant_q.pop_front();
    checked++;
    if (status_o !== g.st) begin
      $display("%0t: status expected %0d actual %0d", $realtime, g.st, status_o);
      errors++;
    end
    if (granted_addr_o !== g.ad) begin
      $display("%0t: granted_addr expected %0d actual %0d", $realtime, g.ad,
               granted_addr_o);
      errors++;
    end
    if (granted_size_o !== g.sz) begin
      $display("%0t: granted_size expected %0d actual %0d", $realtime, g.sz,
               granted_size_o);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    if (pressure_req != pressure_seen) begin
      pressure_seen = pressure_req;
      hold_left = 400;
    end else if (!no_idle && hold_left == 0 && $urandom_range(0, 199) == 0) begin
      hold_left = $urandom_range(10, 60);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 30);
    end
  end

  function automatic int unsigned pick_live();
    return live_q[$urandom_range(0, live_q.size() - 1)];
  endfunction

  task automatic test_directed();
    write_split(MIN_SPLIT_RST);
    send_item(OP_ALLOC, 1024, 0);   // whole pool
    send_item(OP_ALLOC, 2, 0);      // nothing free
    send_item(OP_FREE, 0, 0);
    send_item(OP_FREE, 0, 0);       // already freed
    send_item(OP_ALLOC, 0, 0);      // tiny
    send_item(OP_ALLOC, 1, 0);
    send_item(OP_ALLOC, 2047, 0);   // larger than the pool
    send_item(OP_ALLOC, 1025, 0);
    send_item(OP_ALLOC, 100, 0);
    send_item(OP_ALLOC, 50, 0);
    send_item(OP_ALLOC, 30, 0);
    send_item(OP_FREE, 0, 1023);    // never granted
    send_item(OP_FREE, 0, 1020);    // lone block
    send_item(OP_FREE, 0, 870);     // lone block
    send_item(OP_FREE, 0, 920);     // merge on both sides
    send_item(OP_ALLOC, 1013, 0);   // no block large enough
    send_item(OP_ALLOC, 700, 0);
    send_item(OP_FREE, 0, 1022);    // merge with free block below
    send_item(OP_FREE, 0, 341);
    send_item(OP_FREE, 0, 1022);
    while (live_q.size() != 0) send_item(OP_FREE, 0, pick_live());
    drain();
  endtask

  task automatic test_random_mix(input int unsigned count, input int unsigned lim);
    int unsigned r, sz;
    write_split(lim);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 48) begin
        sz = $urandom_range(0, 9) < 8 ? $urandom_range(2, 40) : $urandom_range(41, 400);
        send_item(OP_ALLOC, sz, 0);
      end else if (r < 90 && live_q.size() != 0) begin
        send_item(OP_FREE, 0, pick_live());
      end else if (r < 95) begin
        send_item(OP_FREE, 0, $urandom_range(0, 1023));
      end else begin
        send_item(OP_ALLOC, $urandom_range(0, 2047), 0);
      end
    end
    drain();
  endtask

  task automatic test_output_hold();
    no_idle = 1'b1;
    pressure_req++;
    repeat (40) begin
      if (live_q.size() != 0 && $urandom_range(0, 1)) send_item(OP_FREE, 0, pick_live());
      else send_item(OP_ALLOC, $urandom_range(2, 64), 0);
    end
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    heap_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_mix(450, MIN_SPLIT_RST);
    test_random_mix(350, 0);
    test_output_hold();
    test_random_mix(250, 1023);
    test_random_mix(400, $urandom_range(1, 30));
    test_random_mix(200, $urandom_range(100, 1022));
    $display("Covered %0d allocates and %0d frees, %0d refused, %0d results checked,",
             n_alloc, n_free, n_refused, checked);
    $display("split thresholds 0, 10, 1023 and random, with a long output hold-off.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bta_pkg.sv
rtl/core/bta_dpath.sv
rtl/core/bta_ctrl.sv
rtl/core/boundary_tag_allocator_top.sv
tb/tb_top.sv
